FILE: hdl/kpm_pkg.sv
// Package for the keypad to mouse translator: key codes, event codes,
// destinations and the layout of one result entry. No dependencies.
package kpm_pkg;

    localparam int KEY_W  = 10;
    localparam int TYPE_W = 5;
    localparam int VAL_W  = 16;

    // Event types and relative axes.
    localparam logic [TYPE_W-1:0] EV_NONE = 5'd0;
    localparam logic [TYPE_W-1:0] EV_KEY  = 5'd1;
    localparam logic [TYPE_W-1:0] EV_REL  = 5'd2;

    localparam logic [KEY_W-1:0] REL_X       = 10'd0;
    localparam logic [KEY_W-1:0] REL_Y       = 10'd1;
    localparam logic [KEY_W-1:0] REL_HSCROLL = 10'd6;
    localparam logic [KEY_W-1:0] REL_VSCROLL = 10'd8;

    localparam logic [KEY_W-1:0] MB_LEFT   = 10'd272;
    localparam logic [KEY_W-1:0] MB_RIGHT  = 10'd273;
    localparam logic [KEY_W-1:0] MB_MIDDLE = 10'd274;

    // Keyboard key codes that the translator acts on.
    localparam logic [KEY_W-1:0] K_LSHIFT  = 10'd42;
    localparam logic [KEY_W-1:0] K_KPAST   = 10'd55;
    localparam logic [KEY_W-1:0] K_LALT    = 10'd56;
    localparam logic [KEY_W-1:0] K_NUMLOCK = 10'd69;
    localparam logic [KEY_W-1:0] K_KP7     = 10'd71;
    localparam logic [KEY_W-1:0] K_KP8     = 10'd72;
    localparam logic [KEY_W-1:0] K_KP9     = 10'd73;
    localparam logic [KEY_W-1:0] K_KPMINUS = 10'd74;
    localparam logic [KEY_W-1:0] K_KP4     = 10'd75;
    localparam logic [KEY_W-1:0] K_KP5     = 10'd76;
    localparam logic [KEY_W-1:0] K_KP6     = 10'd77;
    localparam logic [KEY_W-1:0] K_KPPLUS  = 10'd78;
    localparam logic [KEY_W-1:0] K_KP1     = 10'd79;
    localparam logic [KEY_W-1:0] K_KP2     = 10'd80;
    localparam logic [KEY_W-1:0] K_KP3     = 10'd81;
    localparam logic [KEY_W-1:0] K_KP0     = 10'd82;
    localparam logic [KEY_W-1:0] K_KPDOT   = 10'd83;
    localparam logic [KEY_W-1:0] K_KPENTER = 10'd96;
    localparam logic [KEY_W-1:0] K_KPSLASH = 10'd98;

    localparam logic signed [VAL_W-1:0] STEP_MAX   = 16'sd32767;
    localparam logic signed [VAL_W-1:0] STEP_MIN   = -16'sd32767;
    localparam logic signed [VAL_W-1:0] STEP_RESET = 16'sd5;

    typedef enum logic [1:0] {
        DST_KBD  = 2'd0,
        DST_MOV  = 2'd1,
        DST_BTN  = 2'd2,
        DST_EXIT = 2'd3
    } dest_t;

    typedef enum logic [1:0] {
        ESC_ENTER   = 2'd0,
        ESC_NUMLOCK = 2'd1,
        ESC_EITHER  = 2'd2,
        ESC_ALSO    = 2'd3
    } esc_mode_t;

    typedef enum logic [1:0] {
        SEL_LEFT   = 2'd0,
        SEL_MIDDLE = 2'd1,
        SEL_RIGHT  = 2'd2,
        SEL_NONE   = 2'd3
    } button_sel_t;

    // One result item, in tdata order from the highest bit down.
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [KEY_W-1:0]  code;
        logic [TYPE_W-1:0] typ;
        dest_t             dst;
    } result_t;

    function automatic logic [KEY_W-1:0] button_code(input button_sel_t sel);
        logic [KEY_W-1:0] c;
        case (sel)
            SEL_MIDDLE: c = MB_MIDDLE;
            SEL_RIGHT:  c = MB_RIGHT;
            default:    c = MB_LEFT;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/keypad_to_mouse_translator.sv
// Keypad to mouse translator top level: decodes key beats, holds the
// modifier and step state, and plays out up to four result beats.
// Depends on kpm_pkg.
//
//  channel   dir  tdata fields (low bit up)                      extra
//  s_axis    in   event_type[4:0] key_code[14:5] key_value[16:15] -
//  m_axis    out  destination[1:0] out_type[6:2] out_code[16:7]   tlast
//                 out_value[32:17]
//  cfg       in   escape_mode in cfg_wdata[1:0], written on cfg_we -
//
// An accepted beat is decoded in the same cycle into a run register that
// holds all of its results (one to four), which then play out one per cycle
// while m_tready is high; an item without results loads no run.
// The next beat is taken in the cycle the last result of a run is taken, and
// a stalled m_tready holds the run and s_tready. Reset clears the flags, the
// run, the escape mode and the button, and sets the step sizes to 5.
module keypad_to_mouse_translator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // event_type, key_code, key_value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // destination, out_type, out_code, out_value, pad
    output logic        m_tlast
);

    logic [1:0]                  escape_mode_reg;
    kpm_pkg::button_sel_t        sel_reg, sel_next;
    logic                        shift_reg, shift_next;
    logic                        alt_reg, alt_next;
    logic                        numlock_reg, numlock_next;
    logic                        nl_esc_reg, nl_esc_next;
    logic                        ent_esc_reg, ent_esc_next;
    logic signed [15:0]          x_step_reg, x_step_next;
    logic signed [15:0]          y_step_reg, y_step_next;

    kpm_pkg::result_t            run_reg [4];
    kpm_pkg::result_t            ent [4];
    logic                        run_valid_reg;
    logic [1:0]                  idx_reg;
    logic [1:0]                  last_idx_reg;
    logic [2:0]                  cnt;

    logic [4:0]                  in_type;
    logic [9:0]                  in_code;
    logic [1:0]                  in_val;
    logic                        down, press, escaped, accept, pop_last;
    logic                        key_accept, load_run;
    logic [9:0]                  btn;
    logic [15:0]                 kval;

    assign in_type = s_tdata[4:0];
    assign in_code = s_tdata[14:5];
    assign in_val  = s_tdata[16:15];
    assign down    = in_val != 2'd0;
    assign press   = in_val == 2'd1;
    assign kval    = {14'd0, in_val};
    assign btn     = kpm_pkg::button_code(sel_reg);

    assign pop_last   = run_valid_reg && m_tready && (idx_reg == last_idx_reg);
    assign s_tready   = !run_valid_reg || pop_last;
    assign accept     = s_tvalid && s_tready;
    assign key_accept = accept && (in_type == kpm_pkg::EV_KEY);
    assign load_run   = key_accept && (cnt != 3'd0);

    always_comb
    begin
        case (kpm_pkg::esc_mode_t'(escape_mode_reg))
            kpm_pkg::ESC_ENTER:   escaped = ent_esc_reg;
            kpm_pkg::ESC_NUMLOCK: escaped = nl_esc_reg;
            default:              escaped = ent_esc_reg || nl_esc_reg;
        endcase
    end

    always_comb
    begin
        sel_next     = sel_reg;
        shift_next   = 1'b0;
        alt_next     = 1'b0;
        numlock_next = 1'b0;
        nl_esc_next  = nl_esc_reg;
        ent_esc_next = ent_esc_reg;
        x_step_next  = x_step_reg;
        y_step_next  = y_step_reg;
        cnt          = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            ent[i] = '{value: 16'd0, code: 10'd0, typ: kpm_pkg::EV_NONE,
                       dst: kpm_pkg::DST_KBD};
        end

        case (in_code)
            kpm_pkg::K_LSHIFT, kpm_pkg::K_LALT, kpm_pkg::K_NUMLOCK:
            begin
                if (down)
                begin
                    // On a modifier press the flags are kept; any other key clears them.
                    shift_next   = shift_reg;
                    alt_next     = alt_reg;
                    numlock_next = numlock_reg;
                    if ((in_code == kpm_pkg::K_LSHIFT && alt_reg && numlock_reg) ||
                        (in_code == kpm_pkg::K_LALT && shift_reg && numlock_reg) ||
                        (in_code == kpm_pkg::K_NUMLOCK && shift_reg && alt_reg))
                    begin
                        ent[0] = '{value: 16'd0, code: 10'd0, typ: kpm_pkg::EV_NONE,
                                   dst: kpm_pkg::DST_EXIT};
                        cnt = 3'd1;
                    end
                    else if (in_code == kpm_pkg::K_NUMLOCK)
                    begin
                        numlock_next = 1'b1;
                        nl_esc_next  = 1'b1;
                    end
                    else
                    begin
                        if (in_code == kpm_pkg::K_LSHIFT)
                        begin
                            shift_next = 1'b1;
                        end
                        else
                        begin
                            alt_next = 1'b1;
                        end
                        ent[0] = '{value: kval, code: in_code, typ: kpm_pkg::EV_KEY,
                                   dst: kpm_pkg::DST_KBD};
                        cnt = 3'd1;
                    end
                end
                else if (in_code == kpm_pkg::K_NUMLOCK)
                begin
                    nl_esc_next = 1'b0;
                end
                else
                begin
                    ent[0] = '{value: kval, code: in_code, typ: kpm_pkg::EV_KEY,
                               dst: kpm_pkg::DST_KBD};
                    cnt = 3'd1;
                end
            end
            kpm_pkg::K_KPENTER:
            begin
                ent_esc_next = down;
            end
            kpm_pkg::K_KP0:
            begin
                if (press)
                begin
                    ent[0] = '{value: 16'd1, code: kpm_pkg::MB_LEFT,
                               typ: kpm_pkg::EV_KEY, dst: kpm_pkg::DST_BTN};
                    cnt = 3'd1;
                end
            end
            kpm_pkg::K_KPDOT:
            begin
                // While the NumLock escape is held, dot produces no result.
                if (press && !nl_esc_reg)
                begin
                    ent[0] = '{value: 16'd0, code: kpm_pkg::MB_LEFT,
                               typ: kpm_pkg::EV_KEY, dst: kpm_pkg::DST_BTN};
                    cnt = 3'd1;
                end
            end
            kpm_pkg::K_KP1, kpm_pkg::K_KP3, kpm_pkg::K_KP7, kpm_pkg::K_KP9,
            kpm_pkg::K_KP2, kpm_pkg::K_KP4, kpm_pkg::K_KP6, kpm_pkg::K_KP8:
            begin
                if (down)
                begin
                    if (escaped && (in_code == kpm_pkg::K_KP2 || in_code == kpm_pkg::K_KP8 ||
                                    in_code == kpm_pkg::K_KP4 || in_code == kpm_pkg::K_KP6))
                    begin
                        ent[0].dst  = kpm_pkg::DST_MOV;
                        ent[0].typ  = kpm_pkg::EV_REL;
                        ent[0].code = (in_code == kpm_pkg::K_KP2 || in_code == kpm_pkg::K_KP8)
                                      ? kpm_pkg::REL_VSCROLL : kpm_pkg::REL_HSCROLL;
                        ent[0].value = (in_code == kpm_pkg::K_KP2 || in_code == kpm_pkg::K_KP4)
                                       ? 16'hFFFF : 16'd1;
                        cnt = 3'd1;
                    end
                    else
                    begin
                        ent[0].dst  = kpm_pkg::DST_MOV;
                        ent[0].typ  = kpm_pkg::EV_REL;
                        ent[0].code = kpm_pkg::REL_X;
                        ent[1].dst  = kpm_pkg::DST_MOV;
                        ent[1].typ  = kpm_pkg::EV_REL;
                        ent[1].code = kpm_pkg::REL_Y;
                        case (in_code)
                            kpm_pkg::K_KP1, kpm_pkg::K_KP4, kpm_pkg::K_KP7:
                                ent[0].value = 16'(16'sd0 - x_step_reg);
                            kpm_pkg::K_KP3, kpm_pkg::K_KP6, kpm_pkg::K_KP9:
                                ent[0].value = x_step_reg;
                            default:
                                ent[0].value = 16'd0;
                        endcase
                        case (in_code)
                            kpm_pkg::K_KP7, kpm_pkg::K_KP8, kpm_pkg::K_KP9:
                                ent[1].value = 16'(16'sd0 - y_step_reg);
                            kpm_pkg::K_KP1, kpm_pkg::K_KP2, kpm_pkg::K_KP3:
                                ent[1].value = y_step_reg;
                            default:
                                ent[1].value = 16'd0;
                        endcase
                        cnt = 3'd2;
                    end
                end
            end
            kpm_pkg::K_KP5, kpm_pkg::K_KPPLUS:
            begin
                if (in_code == kpm_pkg::K_KPPLUS && nl_esc_reg && down)
                begin
                    if (y_step_reg != kpm_pkg::STEP_MAX)
                    begin
                        y_step_next = y_step_reg + 16'sd1;
                    end
                end
                else if (press)
                begin
                    // Press and release pairs; plus repeats the pair.
                    for (int i = 0; i < 4; i++)
                    begin
                        ent[i] = '{value: (i % 2 == 0) ? 16'd1 : 16'd0, code: btn,
                                   typ: kpm_pkg::EV_KEY, dst: kpm_pkg::DST_BTN};
                    end
                    cnt = (in_code == kpm_pkg::K_KPPLUS) ? 3'd4 : 3'd2;
                end
            end
            kpm_pkg::K_KPSLASH, kpm_pkg::K_KPAST, kpm_pkg::K_KPMINUS:
            begin
                if (nl_esc_reg && down)
                begin
                    if (in_code == kpm_pkg::K_KPSLASH)
                    begin
                        if (x_step_reg != kpm_pkg::STEP_MIN)
                        begin
                            x_step_next = x_step_reg - 16'sd1;
                        end
                    end
                    else if (in_code == kpm_pkg::K_KPAST)
                    begin
                        if (x_step_reg != kpm_pkg::STEP_MAX)
                        begin
                            x_step_next = x_step_reg + 16'sd1;
                        end
                    end
                    else if (y_step_reg != kpm_pkg::STEP_MIN)
                    begin
                        y_step_next = y_step_reg - 16'sd1;
                    end
                end
                else if (press)
                begin
                    sel_next = (in_code == kpm_pkg::K_KPSLASH) ? kpm_pkg::SEL_LEFT :
                               (in_code == kpm_pkg::K_KPAST)   ? kpm_pkg::SEL_MIDDLE :
                                                                 kpm_pkg::SEL_RIGHT;
                end
            end
            default:
            begin
                ent[0] = '{value: kval, code: in_code, typ: kpm_pkg::EV_KEY,
                           dst: kpm_pkg::DST_KBD};
                cnt = 3'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_mode_reg <= 2'd0;
            sel_reg         <= kpm_pkg::SEL_LEFT;
            shift_reg       <= 1'b0;
            alt_reg         <= 1'b0;
            numlock_reg     <= 1'b0;
            nl_esc_reg      <= 1'b0;
            ent_esc_reg     <= 1'b0;
            x_step_reg      <= kpm_pkg::STEP_RESET;
            y_step_reg      <= kpm_pkg::STEP_RESET;
            run_valid_reg   <= 1'b0;
            idx_reg         <= 2'd0;
            last_idx_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                escape_mode_reg <= cfg_wdata;
            end
            if (key_accept)
            begin
                sel_reg     <= sel_next;
                shift_reg   <= shift_next;
                alt_reg     <= alt_next;
                numlock_reg <= numlock_next;
                nl_esc_reg  <= nl_esc_next;
                ent_esc_reg <= ent_esc_next;
                x_step_reg  <= x_step_next;
                y_step_reg  <= y_step_next;
            end
            if (load_run)
            begin
                run_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
                last_idx_reg  <= 2'(cnt - 3'd1);
            end
            else
            begin
                if (run_valid_reg && m_tready)
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
                if (pop_last)
                begin
                    run_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_run)
        begin
            for (int i = 0; i < 4; i++)
            begin
                run_reg[i] <= ent[i];
            end
        end
    end

    assign m_tvalid = run_valid_reg;
    assign m_tdata  = {7'd0, run_reg[idx_reg]};
    assign m_tlast  = idx_reg == last_idx_reg;

endmodule
